// ===== hw/rtl/salm_pkg.sv =====
package salm_pkg;

  // Frame and field geometry
  localparam int unsigned SEGMENTS   = 32;
  localparam int unsigned IDX_W      = 5;
  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned MAG_W      = 17;
  localparam int unsigned LEVEL_W    = 14;
  localparam int unsigned LEN_W      = 13;
  localparam int unsigned POS_W      = 12;
  localparam int unsigned SEG_SUM_W  = 28;
  localparam int unsigned FRM_SUM_W  = 33;
  localparam int unsigned FRM_SHIFT  = 5;   // log2 of SEGMENTS
  localparam int unsigned DIV_W      = 28;
  localparam int unsigned DIV_CNT_W  = 5;
  localparam int unsigned OUT_DATA_W = 40;

  localparam logic [LEN_W-1:0]     MAX_LEN     = 13'd4096;
  localparam logic [LEN_W-1:0]     RESET_LEN   = 13'd32;
  localparam logic [LEVEL_W-1:0]   FULL_SCALE  = 14'd8192;
  localparam logic [IDX_W-1:0]     LAST_IDX    = 5'(SEGMENTS - 1);
  localparam logic [DIV_CNT_W-1:0] DIV_LAST    = 5'(DIV_W - 1);

  // Sequencer states
  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SEG  = 4'b0010,
    S_FRM  = 4'b0100,
    S_OUT  = 4'b1000
  } state_e;

  // Clamp a quotient to full scale
  function automatic logic [LEVEL_W-1:0] clamp_level(input logic [DIV_W-1:0] v);
    logic [LEVEL_W-1:0] r;
    if (v > DIV_W'(FULL_SCALE)) r = FULL_SCALE;
    else                        r = v[LEVEL_W-1:0];
    return r;
  endfunction

endpackage

// ===== hw/rtl/segmented_audio_level_meter.sv =====
// A sample that does not end a segment is taken while the meter is idle, and the
// next sample may follow in the next cycle. A segment-ending sample starts the
// shared radix-2 divider in S_SEG for the segment level, then in S_FRM for the frame
// level on the last segment, then S_OUT loads the output register once it may.
// Reset clears the sums, counters and stored levels and sets the length to 32.
module segmented_audio_level_meter
  import salm_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration: segment length
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [LEN_W-1:0]      cfg_data_i,
  // input items
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [SAMPLE_W-1:0]   s_axis_tdata,   // [15:0] sample
  // result items
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,   // [4:0] segment_index,
                                                // [18:5] segment_level,
                                                // [32:19] frame_level, rest 0
  output logic                  m_axis_tlast    // frame_done
);

  state_e                 state_q, state_d;
  logic [LEN_W-1:0]       len_cfg_q;
  logic [LEN_W-1:0]       len_q;
  logic [LEN_W-1:0]       eff_len;
  logic [SEG_SUM_W-1:0]   seg_sum_q;
  logic [FRM_SUM_W-1:0]   frm_sum_q;
  logic [POS_W-1:0]       pos_q;
  logic [IDX_W-1:0]       seg_cnt_q;
  logic [IDX_W-1:0]       cur_idx_q;
  logic                   last_q;
  logic [LEVEL_W-1:0]     levels_q [SEGMENTS];
  logic [LEVEL_W-1:0]     seg_level_q;
  logic [LEVEL_W-1:0]     frm_level_q;

  logic [DIV_W-1:0]       div_num_q;
  logic [LEN_W-1:0]       div_rem_q;
  logic [DIV_CNT_W-1:0]   div_cnt_q;

  logic                   m_valid_q;
  logic                   m_last_q;
  logic [OUT_DATA_W-1:0]  m_data_q;

  logic                   in_fire;
  logic [MAG_W-1:0]       mag;
  logic [SEG_SUM_W-1:0]   seg_sum_new;
  logic [FRM_SUM_W-1:0]   frm_sum_new;
  logic                   seg_end;
  logic [LEVEL_W:0]       div_shift;
  logic                   div_ge;
  logic [DIV_W-1:0]       div_num_nx;
  logic [LEN_W-1:0]       div_rem_nx;
  logic                   div_done;
  logic [LEVEL_W-1:0]     seg_level_new;
  logic [LEVEL_W:0]       smooth_sum;
  logic                   out_load;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == S_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  // Length in force: zero acts as one, large values saturate
  always_comb begin
    eff_len = len_cfg_q;
    if (len_cfg_q == '0)    eff_len = LEN_W'(1);
    if (len_cfg_q > MAX_LEN) eff_len = MAX_LEN;
  end

  // Sample magnitude and running sums
  assign mag = s_axis_tdata[SAMPLE_W-1] ? (MAG_W'(0) - {1'b1, s_axis_tdata})
                                        : {1'b0, s_axis_tdata};
  assign seg_sum_new = seg_sum_q + SEG_SUM_W'(mag);
  assign frm_sum_new = frm_sum_q + FRM_SUM_W'(mag);
  assign seg_end     = ({1'b0, pos_q} + LEN_W'(1)) >= eff_len;

  // One restoring-division step
  assign div_shift  = {1'b0, div_rem_q, div_num_q[DIV_W-1]};
  assign div_ge     = div_shift >= (LEVEL_W+1)'(len_q);
  assign div_rem_nx = div_ge ? LEN_W'(div_shift - (LEVEL_W+1)'(len_q))
                             : div_shift[LEN_W-1:0];
  assign div_num_nx = {div_num_q[DIV_W-2:0], div_ge};
  assign div_done   = (div_cnt_q == DIV_LAST);

  // Smoothing against the stored level
  assign seg_level_new = clamp_level(div_num_nx);
  assign smooth_sum    = {1'b0, levels_q[cur_idx_q]} + {1'b0, seg_level_new};

  assign out_load = (state_q == S_OUT) && (!m_valid_q || m_axis_tready);

  // Sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (in_fire && seg_end) state_d = S_SEG;
      S_SEG:  if (div_done) state_d = last_q ? S_FRM : S_OUT;
      S_FRM:  if (div_done) state_d = S_OUT;
      S_OUT:  if (out_load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_cfg_q <= RESET_LEN;
    end else if (cfg_valid_i && cfg_ready_o) begin
      len_cfg_q <= cfg_data_i;
    end
  end

  // Accumulators, counters and stored levels
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_sum_q <= '0;
      frm_sum_q <= '0;
      pos_q     <= '0;
      seg_cnt_q <= '0;
      cur_idx_q <= '0;
      last_q    <= 1'b0;
      for (int i = 0; i < SEGMENTS; i++) begin
        levels_q[i] <= '0;
      end
    end else begin
      if (in_fire) begin
        frm_sum_q <= frm_sum_new;
        if (seg_end) begin
          seg_sum_q <= '0;
          pos_q     <= '0;
          cur_idx_q <= seg_cnt_q;
          last_q    <= (seg_cnt_q == LAST_IDX);
          seg_cnt_q <= (seg_cnt_q == LAST_IDX) ? '0 : seg_cnt_q + IDX_W'(1);
        end else begin
          seg_sum_q <= seg_sum_new;
          pos_q     <= pos_q + POS_W'(1);
        end
      end
      if (state_q == S_SEG && div_done) begin
        levels_q[cur_idx_q] <= smooth_sum[LEVEL_W:1];
        // frame numerator is handed to the divider now
        if (last_q) frm_sum_q <= '0;
      end
    end
  end

  // Shared divider and level holding registers
  always_ff @(posedge clk_i) begin
    if (in_fire && seg_end) begin
      div_num_q <= seg_sum_new;
      div_rem_q <= '0;
      div_cnt_q <= '0;
      len_q     <= eff_len;
    end else if (state_q == S_SEG || state_q == S_FRM) begin
      div_cnt_q <= div_cnt_q + DIV_CNT_W'(1);
      div_num_q <= div_num_nx;
      div_rem_q <= div_rem_nx;
      if (state_q == S_SEG && div_done) begin
        seg_level_q <= smooth_sum[LEVEL_W:1];
        frm_level_q <= '0;
        div_num_q   <= frm_sum_q[FRM_SUM_W-1:FRM_SHIFT];
        div_rem_q   <= '0;
        div_cnt_q   <= '0;
      end
      if (state_q == S_FRM && div_done) begin
        frm_level_q <= seg_level_new;
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
      m_last_q  <= 1'b0;
    end else if (out_load) begin
      m_valid_q <= 1'b1;
      m_last_q  <= last_q;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      m_data_q <= {7'd0, frm_level_q, seg_level_q, cur_idx_q};
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tlast  = m_last_q;
  assign m_axis_tdata  = m_data_q;

  // Checks
  a_last_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[4:0] == LAST_IDX)
    else $error("frame end on a segment other than the last");

  a_seg_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[18:5] <= FULL_SCALE)
    else $error("segment level above full scale");

  a_frm_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tlast |-> m_axis_tdata[32:19] == '0)
    else $error("frame level set outside frame end");

  a_div_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SEG || state_q == S_FRM) |-> div_cnt_q <= DIV_LAST)
    else $error("divider step count overrun");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_OUT && m_axis_tvalid && !m_axis_tready |=> state_q == S_OUT)
    else $error("result dropped while output stalled");

endmodule

// ===== tb/level_meter_checker.sv =====
`timescale 1ns / 1ps

// Watches the configuration, sample and result channels of the level meter.
// It keeps its own copy of the meter state and queues the expected result items.
module level_meter_checker
  import salm_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  input  logic                  cfg_ready_i,
  input  logic [LEN_W-1:0]      cfg_data_i,
  input  logic                  s_tvalid_i,
  input  logic                  s_tready_i,
  input  logic [SAMPLE_W-1:0]   s_tdata_i,    // [15:0] sample
  input  logic                  m_tvalid_i,
  input  logic                  m_tready_i,
  input  logic [OUT_DATA_W-1:0] m_tdata_i,    // [4:0] segment_index, [18:5] segment_level,
                                              // [32:19] frame_level, rest 0
  input  logic                  m_tlast_i,    // frame_done
  output int                    error_count_o,
  output int                    pending_o,
  output int                    result_count_o,
  output int                    frame_count_o
);

  localparam int unsigned SEG_LO = IDX_W;
  localparam int unsigned FRM_LO = IDX_W + LEVEL_W;
  localparam int unsigned PAD_LO = IDX_W + 2 * LEVEL_W;

  typedef struct packed {
    logic [IDX_W-1:0]   index;
    logic [LEVEL_W-1:0] seg_level;
    logic [LEVEL_W-1:0] frm_level;
    logic               done;
  } level_result_t;

  level_result_t      level_q[$];

  // Shadow copy of the meter state
  logic [LEN_W-1:0]     seg_len_q;
  logic [SEG_SUM_W-1:0] seg_sum_q;
  logic [FRM_SUM_W-1:0] frm_sum_q;
  logic [POS_W-1:0]     pos_q;
  logic [IDX_W-1:0]     seg_cnt_q;
  logic [LEVEL_W-1:0]   smoothed_q [SEGMENTS];

  always @(posedge clk_i) begin : track
    logic [MAG_W-1:0]     mag;
    logic [LEN_W-1:0]     len;
    logic [SEG_SUM_W-1:0] seg_total;
    logic [FRM_SUM_W-1:0] frm_total;
    logic [SEG_SUM_W-1:0] seg_quot;
    logic [FRM_SUM_W-1:0] frm_quot;
    logic [LEVEL_W-1:0]   level;
    logic [LEVEL_W:0]     avg_sum;
    level_result_t        got;
    level_result_t        want;
    level_result_t        res;

    if (!rst_ni) begin
      seg_len_q      = RESET_LEN;
      seg_sum_q      = '0;
      frm_sum_q      = '0;
      pos_q          = '0;
      seg_cnt_q      = '0;
      for (int i = 0; i < SEGMENTS; i++) smoothed_q[i] = '0;
      level_q.delete();
      error_count_o  = 0;
      result_count_o = 0;
      frame_count_o  = 0;
    end else begin
      // compare an accepted result item with the oldest expectation
      if (m_tvalid_i && m_tready_i) begin
        result_count_o++;
        if (m_tlast_i) frame_count_o++;
        got.index     = m_tdata_i[IDX_W-1:0];
        got.seg_level = m_tdata_i[SEG_LO +: LEVEL_W];
        got.frm_level = m_tdata_i[FRM_LO +: LEVEL_W];
        got.done      = m_tlast_i;
        if (level_q.size() == 0) begin
          $error("result item with nothing expected: tdata=%h tlast=%b", m_tdata_i, m_tlast_i);
          error_count_o++;
        end else begin
          want = level_q.pop_front();
          if (got.index !== want.index) begin
            $error("segment_index: expected %0d, actual %0d", want.index, got.index);
            error_count_o++;
          end
          if (got.seg_level !== want.seg_level) begin
            $error("segment_level: expected %0d, actual %0d", want.seg_level, got.seg_level);
            error_count_o++;
          end
          if (got.frm_level !== want.frm_level) begin
            $error("frame_level: expected %0d, actual %0d", want.frm_level, got.frm_level);
            error_count_o++;
          end
          if (got.done !== want.done) begin
            $error("frame_done: expected %0d, actual %0d", want.done, got.done);
            error_count_o++;
          end
          if (m_tdata_i[OUT_DATA_W-1:PAD_LO] !== '0) begin
            $error("tdata padding: expected 0, actual %h", m_tdata_i[OUT_DATA_W-1:PAD_LO]);
            error_count_o++;
          end
        end
      end

      // length register; counters and sums are left alone
      if (cfg_valid_i && cfg_ready_i) seg_len_q = cfg_data_i;

      // accumulate an accepted sample, close the segment when it is full
      if (s_tvalid_i && s_tready_i) begin
        mag = s_tdata_i[SAMPLE_W-1] ? (MAG_W'(17'h10000) - MAG_W'(s_tdata_i))
                                    : MAG_W'(s_tdata_i);
        if (seg_len_q == '0)         len = LEN_W'(1);
        else if (seg_len_q > MAX_LEN) len = MAX_LEN;
        else                          len = seg_len_q;
        seg_total = seg_sum_q + SEG_SUM_W'(mag);
        frm_total = frm_sum_q + FRM_SUM_W'(mag);

        if ({1'b0, pos_q} + LEN_W'(1) < len) begin
          pos_q     = pos_q + POS_W'(1);
          seg_sum_q = seg_total;
          frm_sum_q = frm_total;
        end else begin
          seg_quot = seg_total / SEG_SUM_W'(len);
          level    = (seg_quot > SEG_SUM_W'(FULL_SCALE)) ? FULL_SCALE : seg_quot[LEVEL_W-1:0];
          // smoothing halves with truncation
          avg_sum  = {1'b0, smoothed_q[seg_cnt_q]} + {1'b0, level};
          smoothed_q[seg_cnt_q] = avg_sum[LEVEL_W:1];

          res.index     = seg_cnt_q;
          res.seg_level = avg_sum[LEVEL_W:1];
          res.done      = (seg_cnt_q == LAST_IDX);
          res.frm_level = '0;
          if (res.done) begin
            frm_quot      = frm_total / (FRM_SUM_W'(len) << FRM_SHIFT);
            res.frm_level = (frm_quot > FRM_SUM_W'(FULL_SCALE)) ? FULL_SCALE
                                                                : frm_quot[LEVEL_W-1:0];
          end
          level_q = {level_q, res};

          pos_q     = '0;
          seg_sum_q = '0;
          frm_sum_q = res.done ? '0 : frm_total;
          seg_cnt_q = res.done ? '0 : seg_cnt_q + IDX_W'(1);
        end
      end
    end
    pending_o = level_q.size();
  end

endmodule

// ===== tb/segmented_audio_level_meter_tb.sv =====
`timescale 1ns / 1ps

module segmented_audio_level_meter_tb;
  import salm_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int SETTLE      = 64;   // longer than the frame path through the divider and output register
  localparam int NUM_PHASES  = 16;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [LEN_W-1:0]      cfg_data;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [SAMPLE_W-1:0]   s_axis_tdata;   // [15:0] sample
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;   // [4:0] segment_index, [18:5] segment_level,
                                         // [32:19] frame_level, rest 0
  logic                  m_axis_tlast;   // frame_done

  logic s_fire;
  logic cfg_fire;
  int   error_count;
  int   pending;
  int   result_count;
  int   frame_count;
  int   cycle_count = 0;
  int   sample_count = 0;
  int   setting_count = 0;

  segmented_audio_level_meter u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_data_i    (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  level_meter_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_i    (cfg_ready),
    .cfg_data_i     (cfg_data),
    .s_tvalid_i     (s_axis_tvalid),
    .s_tready_i     (s_axis_tready),
    .s_tdata_i      (s_axis_tdata),
    .m_tvalid_i     (m_axis_tvalid),
    .m_tready_i     (m_axis_tready),
    .m_tdata_i      (m_axis_tdata),
    .m_tlast_i      (m_axis_tlast),
    .error_count_o  (error_count),
    .pending_o      (pending),
    .result_count_o (result_count),
    .frame_count_o  (frame_count)
  );

  // 50 MHz clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // handshakes seen at the rising edge, read by the drivers at the falling edge
  always @(posedge clk_i) begin
    s_fire   <= s_axis_tvalid && s_axis_tready;
    cfg_fire <= cfg_valid && cfg_ready;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $error("watchdog expired with %0d result items outstanding", pending);
      $display("simulation failed");
      $finish;
    end
  end

  // result backpressure: short stalls, a few long ones, some stall-free stretches
  initial begin : sink_stall
    int pick;
    int span;
    m_axis_tready = 1'b0;
    @(negedge clk_i);
    forever begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        m_axis_tready = 1'b1;
        span = $urandom_range(1, 8);
      end else if (pick < 85) begin
        m_axis_tready = 1'b0;
        span = $urandom_range(1, 3);
      end else if (pick < 94) begin
        m_axis_tready = 1'b0;
        span = $urandom_range(10, 40);
      end else begin
        m_axis_tready = 1'b1;
        span = $urandom_range(50, 150);
      end
      repeat (span) @(negedge clk_i);
    end
  end

  // sender gap: mostly none or short, now and then long
  function automatic int pick_gap();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 50) return 0;
    if (pick < 85) return $urandom_range(1, 3);
    if (pick < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // mix of extremes, full-range noise and quiet content below full scale
  function automatic logic [SAMPLE_W-1:0] rand_sample();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 6)  return 16'h8000;
    if (pick < 10) return 16'h7FFF;
    if (pick < 14) return '0;
    if (pick < 55) return SAMPLE_W'($urandom);
    return SAMPLE_W'($urandom_range(0, 16383)) - 16'd8192;
  endfunction

  task automatic send_sample(input logic [SAMPLE_W-1:0] value, input bit no_gap);
    int gap;
    s_axis_tdata  = value;
    s_axis_tvalid = 1'b1;
    do @(negedge clk_i); while (!s_fire);
    sample_count++;
    gap = no_gap ? 0 : pick_gap();
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  task automatic wait_drained();
    s_axis_tvalid = 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  // length writes only with the meter idle and every result delivered
  task automatic write_length(input logic [LEN_W-1:0] value);
    wait_drained();
    repeat (SETTLE) @(negedge clk_i);
    cfg_data  = value;
    cfg_valid = 1'b1;
    do @(negedge clk_i); while (!cfg_fire);
    cfg_valid = 1'b0;
    setting_count++;
  endtask

  initial begin : stimulus
    logic [SAMPLE_W-1:0] directed [24];
    logic [LEN_W-1:0]    len;
    int                  items;
    bit                  burst;

    rst_ni        = 1'b0;
    cfg_valid     = 1'b0;
    cfg_data      = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    directed = '{16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF, 16'h0001, 16'h8001,
                 16'h2000, 16'hE000, 16'h1FFF, 16'hDFFF, 16'h4000, 16'h1000,
                 16'h0003, 16'hFFFD, 16'h5555, 16'hAAAA, 16'h7FFE, 16'h8000,
                 16'h0000, 16'h7FFF, 16'h8000, 16'h0001, 16'hFFFE, 16'h2001};

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: one sample per segment, then a length of zero that acts as one
    write_length(LEN_W'(1));
    for (int i = 0; i < 18; i++) send_sample(directed[i], 1'b0);
    write_length(LEN_W'(0));
    for (int i = 18; i < 24; i++) send_sample(directed[i], 1'b0);

    // random phases; lengths change with partial segments pending
    for (int p = 0; p < NUM_PHASES; p++) begin
      burst = 1'b0;
      case (p)
        0:  begin len = LEN_W'(5);    items = 30;   end
        1:  begin len = LEN_W'(2);    items = 30;   end
        2:  begin len = LEN_W'(13);   items = 40;   end
        3:  begin len = LEN_W'(8191); items = 10;   end
        4:  begin len = LEN_W'(3);    items = 20;   end
        5:  begin len = MAX_LEN;      items = 60;   burst = 1'b1; end
        6:  begin len = LEN_W'(1);    items = 40;   end
        7:  begin len = LEN_W'(7);    items = 25;   end
        8:  begin len = LEN_W'(4097); items = 10;   end
        9:  begin len = LEN_W'(2);    items = 20;   end
        10: begin len = LEN_W'(0);    items = 20;   burst = 1'b1; end
        11: begin len = RESET_LEN;    items = 40;   end
        default: begin
          len   = LEN_W'($urandom_range(1, 12));
          items = 15;
        end
      endcase
      write_length(len);
      for (int k = 0; k < items; k++) begin
        // hold the sender once until the meter has delivered everything
        if (p == 0 && k == items / 2) wait_drained();
        // the long segment and the zero-length phase mostly run back to back
        send_sample(rand_sample(), burst && ($urandom_range(0, 9) != 0));
      end
    end

    wait_drained();
    repeat (SETTLE) @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);

    $display("Covered %0d samples under %0d length settings: %0d segment results, %0d frames.",
             sample_count, setting_count, result_count, frame_count);
    $display("Lengths ran from 0 and 1 up to 4096 and above, changed inside open segments.");
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
